// ----- rtl/swfrm_pkg.sv -----
// Shared constants and types for the sliding window frame rate meter.
package swfrm_pkg;

   localparam int RING_DEPTH = 256;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int COUNT_W    = RING_AW + 1;
   localparam int TICK_BITS  = 16;
   localparam int WSUM_W     = TICK_BITS + RING_AW;
   localparam int WLEN_W     = 24;
   localparam int TOT_W      = 48;
   localparam int FCNT_W     = 32;
   localparam int RATE_W     = 32;
   localparam int FRAC_BITS  = 16;
   localparam int DIV_W      = 48;
   localparam int ITER_W     = $clog2(DIV_W + 1);
   localparam int WNUM_W     = COUNT_W + FRAC_BITS;
   localparam int RSP_BITS   = RATE_W + COUNT_W + 1 + RATE_W + 1;
   localparam int RSP_W      = ((RSP_BITS + 7) / 8) * 8;
   localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(1000);

   typedef struct packed {
      logic                 wr_en;
      logic [RING_AW-1:0]   wr_addr;
      logic [TICK_BITS-1:0] wr_data;
      logic                 rd_en;
      logic [RING_AW-1:0]   rd_addr;
   } ring_req_type;

   typedef struct packed {
      logic              start;
      logic [ITER_W-1:0] iters;
      logic [DIV_W-1:0]  dividend;
      logic [DIV_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- rtl/swfrm_ring.sv -----
// Duration ring memory with one write port and one registered read port.
module swfrm_ring (
   input  logic                            clock,
   input  swfrm_pkg::ring_req_type         ring_req,
   output logic [swfrm_pkg::TICK_BITS-1:0] rd_data
);
   import swfrm_pkg::*;

   logic [TICK_BITS-1:0] ring_mem [RING_DEPTH];
   logic [TICK_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ring_req.wr_en) begin
         ring_mem[ring_req.wr_addr] <= ring_req.wr_data;
      end
      if (ring_req.rd_en) begin
         rd_data_ff <= ring_mem[ring_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/swfrm_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
module swfrm_div (
   input  logic                   clock,
   input  logic                   reset,
   input  swfrm_pkg::div_req_type div_req,
   output swfrm_pkg::div_rsp_type div_rsp
);
   import swfrm_pkg::*;

   logic              busy_ff, busy_in;
   logic [ITER_W-1:0] left_ff, left_in;
   logic [DIV_W-1:0]  dvd_ff, dvd_in;
   logic [DIV_W-1:0]  dvs_ff, dvs_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic              done_ff, done_in;
   logic [DIV_W:0]    rem_shift;
   logic [DIV_W:0]    rem_diff;
   logic              fits;

   assign rem_shift = {rem_ff, dvd_ff[DIV_W-1]};
   assign fits      = rem_shift >= {1'b0, dvs_ff};
   assign rem_diff  = rem_shift - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      left_in = left_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         busy_in = 1'b1;
         left_in = div_req.iters;
         dvd_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[DIV_W-2:0], 1'b0};
         rem_in  = fits ? rem_diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
         quo_in  = {quo_ff[DIV_W-2:0], fits};
         left_in = left_ff - ITER_W'(1);
         if (left_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      left_ff <= left_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ----- rtl/sliding_window_frame_rate_meter_unit.sv -----
// Top level of the sliding window frame rate meter: sequencer, state and result register.
// A transaction runs a pop of the oldest duration if the ring is full, the push, the window
// division, trimming of evicted durations, the overall division and the result register; a
// zero window sum or zero total skips its division. One transaction is processed at a time;
// another is taken while a result waits, and a stalled result holds it in its last state.
// Synchronous reset clears the counts and sets the window length to 1000; ring memory is kept.
module sliding_window_frame_rate_meter_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [15:0]                   req_tdata,   // [15:0] frame_ticks
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [swfrm_pkg::RSP_W-1:0]   rsp_tdata,   // [31:0] window_rate, [40:32]
                                                      // window_frames, [41] window_zero,
                                                      // [73:42] overall_rate,
                                                      // [74] overall_zero, rest zero
   input  logic                          csr_wr_en,
   input  logic [swfrm_pkg::WLEN_W-1:0]  csr_wr_data
);
   import swfrm_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_FULLPOP = 4'd1;
   localparam logic [3:0] S_PUSH    = 4'd2;
   localparam logic [3:0] S_WSTART  = 4'd3;
   localparam logic [3:0] S_WDIV    = 4'd4;
   localparam logic [3:0] S_TRIM    = 4'd5;
   localparam logic [3:0] S_TRIM_RD = 4'd6;
   localparam logic [3:0] S_OSTART  = 4'd7;
   localparam logic [3:0] S_ODIV    = 4'd8;
   localparam logic [3:0] S_DONE    = 4'd9;

   localparam logic [RATE_W-1:0] RATE_SAT = '1;

   logic [3:0]           state_ff, state_in;
   logic [TICK_BITS-1:0] ticks_ff, ticks_in;
   logic [RING_AW-1:0]   head_ff, head_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [WSUM_W-1:0]    wsum_ff, wsum_in;
   logic [TOT_W-1:0]     ttot_ff, ttot_in;
   logic [FCNT_W-1:0]    fcnt_ff, fcnt_in;
   logic [WLEN_W-1:0]    wlen_ff, wlen_in;
   logic [COUNT_W-1:0]   frames_ff, frames_in;
   logic [RATE_W-1:0]    wrate_ff, wrate_in;
   logic                 wz_ff, wz_in;
   logic [RATE_W-1:0]    orate_ff, orate_in;
   logic                 oz_ff, oz_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]     rsp_data_ff, rsp_data_in;

   ring_req_type         ring_req;
   logic [TICK_BITS-1:0] ring_rd_data;
   div_req_type          div_req;
   div_rsp_type          div_rsp;
   logic [TOT_W:0]       ttot_sum;
   logic [RATE_W-1:0]    quo_sat;
   logic                 req_fire;
   logic                 out_free;

   swfrm_ring u_ring (
      .clock    (clock),
      .ring_req (ring_req),
      .rd_data  (ring_rd_data)
   );

   swfrm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign ttot_sum   = {1'b0, ttot_ff} + (TOT_W + 1)'(ticks_ff);
   assign quo_sat    = (div_rsp.quotient[DIV_W-1:RATE_W] != '0) ? RATE_SAT
                                                                : div_rsp.quotient[RATE_W-1:0];

   always_comb begin
      state_in     = state_ff;
      ticks_in     = ticks_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      wsum_in      = wsum_ff;
      ttot_in      = ttot_ff;
      fcnt_in      = fcnt_ff;
      wlen_in      = csr_wr_en ? csr_wr_data : wlen_ff;
      frames_in    = frames_ff;
      wrate_in     = wrate_ff;
      wz_in        = wz_ff;
      orate_in     = orate_ff;
      oz_in        = oz_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ring_req         = '0;
      ring_req.rd_addr = head_ff;
      ring_req.wr_addr = head_ff + count_ff[RING_AW-1:0];
      ring_req.wr_data = ticks_ff;
      div_req          = '0;

      unique case (state_ff)
         S_IDLE: begin
            ring_req.rd_en = 1'b1;
            if (req_fire) begin
               ticks_in = req_tdata[TICK_BITS-1:0];
               state_in = (count_ff == COUNT_W'(RING_DEPTH)) ? S_FULLPOP : S_PUSH;
            end
         end
         S_FULLPOP: begin
            wsum_in  = wsum_ff - WSUM_W'(ring_rd_data);
            head_in  = head_ff + RING_AW'(1);
            count_in = count_ff - COUNT_W'(1);
            state_in = S_PUSH;
         end
         S_PUSH: begin
            ring_req.wr_en = 1'b1;
            count_in = count_ff + COUNT_W'(1);
            wsum_in  = wsum_ff + WSUM_W'(ticks_ff);
            ttot_in  = ttot_sum[TOT_W] ? '1 : ttot_sum[TOT_W-1:0];
            fcnt_in  = (fcnt_ff == '1) ? fcnt_ff : fcnt_ff + FCNT_W'(1);
            state_in = S_WSTART;
         end
         S_WSTART: begin
            frames_in = count_ff;
            if (wsum_ff == '0) begin
               wrate_in = RATE_SAT;
               wz_in    = 1'b1;
               state_in = S_TRIM;
            end else begin
               wz_in            = 1'b0;
               div_req.start    = 1'b1;
               div_req.iters    = ITER_W'(WNUM_W);
               div_req.dividend = {count_ff, FRAC_BITS'(0), (DIV_W - WNUM_W)'(0)};
               div_req.divisor  = DIV_W'(wsum_ff);
               state_in         = S_WDIV;
            end
         end
         S_WDIV: begin
            if (div_rsp.done) begin
               wrate_in = quo_sat;
               state_in = S_TRIM;
            end
         end
         S_TRIM: begin
            if ((count_ff != '0) && (WLEN_W'(wsum_ff) > wlen_ff)) begin
               ring_req.rd_en = 1'b1;
               state_in       = S_TRIM_RD;
            end else begin
               state_in = S_OSTART;
            end
         end
         S_TRIM_RD: begin
            wsum_in  = wsum_ff - WSUM_W'(ring_rd_data);
            head_in  = head_ff + RING_AW'(1);
            count_in = count_ff - COUNT_W'(1);
            state_in = S_TRIM;
         end
         S_OSTART: begin
            if (ttot_ff == '0) begin
               orate_in = RATE_SAT;
               oz_in    = 1'b1;
               state_in = S_DONE;
            end else begin
               oz_in            = 1'b0;
               div_req.start    = 1'b1;
               div_req.iters    = ITER_W'(DIV_W);
               div_req.dividend = {fcnt_ff, FRAC_BITS'(0)};
               div_req.divisor  = ttot_ff;
               state_in         = S_ODIV;
            end
         end
         S_ODIV: begin
            if (div_rsp.done) begin
               orate_in = quo_sat;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({oz_ff, orate_ff, wz_ff, frames_ff, wrate_ff});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         wsum_ff      <= '0;
         ttot_ff      <= '0;
         fcnt_ff      <= '0;
         wlen_ff      <= WLEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         wsum_ff      <= wsum_in;
         ttot_ff      <= ttot_in;
         fcnt_ff      <= fcnt_in;
         wlen_ff      <= wlen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ticks_ff    <= ticks_in;
      frames_ff   <= frames_in;
      wrate_ff    <= wrate_in;
      wz_ff       <= wz_in;
      orate_ff    <= orate_in;
      oz_ff       <= oz_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
